FILE: sv/ilt_pkg.sv
package ilt_pkg;

    // Default for the longest line the downstream string buffers hold.
    localparam int MAX_LINE_DEF = 4096;
    localparam int SPACE_W      = 12;

    // Parse phases.
    localparam logic [3:0] PH_START     = 4'd0;
    localparam logic [3:0] PH_SECTION   = 4'd1;
    localparam logic [3:0] PH_NAME      = 4'd2;
    localparam logic [3:0] PH_NAME_SP   = 4'd3;
    localparam logic [3:0] PH_VAL_START = 4'd4;
    localparam logic [3:0] PH_VALUE     = 4'd5;
    localparam logic [3:0] PH_VAL_SP    = 4'd6;
    localparam logic [3:0] PH_QUOTE_SP  = 4'd7;
    localparam logic [3:0] PH_SKIP      = 4'd8;

    // Line types.
    localparam logic [2:0] T_SYNTAX      = 3'd0;
    localparam logic [2:0] T_EMPTY       = 3'd1;
    localparam logic [2:0] T_SECTION     = 3'd2;
    localparam logic [2:0] T_NAME_VALUE  = 3'd3;
    localparam logic [2:0] T_EMPTY_VALUE = 3'd4;

    // Destination strings.
    localparam logic [1:0] D_NONE    = 2'd0;
    localparam logic [1:0] D_SECTION = 2'd1;
    localparam logic [1:0] D_NAME    = 2'd2;
    localparam logic [1:0] D_VALUE   = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef struct packed {
        logic [3:0]         phase;
        logic [SPACE_W-1:0] spaces;
        logic               quoted;
    } t_state;

    typedef struct packed {
        logic [1:0]         dest;
        logic               lead_quote;
        logic [SPACE_W-1:0] lead_spaces;
        logic               char_valid;
        logic [7:0]         char_out;
        logic               line_done;
        logic [2:0]         line_type;
    } t_result;

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_HASH) || (c == CH_CR) ||
               (c == CH_LF) || (c == CH_NUL);
    endfunction

endpackage

FILE: sv/ilt_if.sv
interface ilt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface ilt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  dest;
    logic        lead_quote;
    logic [11:0] lead_spaces;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        line_done;
    logic [2:0]  line_type;

    modport source (output valid, output dest, output lead_quote, output lead_spaces,
                    output char_valid, output char_out, output line_done,
                    output line_type, input ready);
    modport sink   (input valid, input dest, input lead_quote, input lead_spaces,
                    input char_valid, input char_out, input line_done,
                    input line_type, output ready);
endinterface

FILE: sv/ini_line_tokenizer.sv
// INI line tokenizer.
// The input channel i_in carries one text byte per request; a zero byte ends
// the current line. The output channel o_out carries exactly one result per
// input byte: the destination string (section, name or value), an optional
// deferred double quote, a count of deferred spaces, an optional character,
// and, on the byte that decides it, the type of the line.
// A byte that is accepted sits in the input register; its result is then
// loaded into the output register, where it is offered until taken.
// Throughput is one byte per cycle while the receiver does not stall;
// the parse state (phase, pending space count, outer-quote flag) is updated
// by one shallow step of logic between the two registers.
// When the receiver stalls, the result waits in the output register while one
// more byte is still taken into the input register; only then does i_in.ready
// drop. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the start of a line with no pending spaces and no open quote.
// MAX_LINE sets the saturation point of the pending space count.
module ini_line_tokenizer
    import ilt_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilt_in_if.sink      i_in,
    ilt_out_if.source   o_out
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;

    // Parse state, advanced once per byte that moves to the output register.
    t_state     r_state;
    t_state     n_state;

    // Output register.
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;

    logic       w_out_free;
    logic       w_adv;

    // The output register can take a new result when it is empty or its
    // current result is being taken in this cycle.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;

    ilt_step #(
        .MAX_LINE (MAX_LINE)
    ) u_step (
        .i_state (r_state),
        .i_byte  (r_byte),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase  <= PH_START;
            r_state.spaces <= '0;
            r_state.quoted <= 1'b0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.dest        = r_res.dest;
    assign o_out.lead_quote  = r_res.lead_quote;
    assign o_out.lead_spaces = r_res.lead_spaces;
    assign o_out.char_valid  = r_res.char_valid;
    assign o_out.char_out    = r_res.char_out;
    assign o_out.line_done   = r_res.line_done;
    assign o_out.line_type   = r_res.line_type;

    // At a line start there is never a pending space or an open quote.
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_START) |-> (r_state.spaces == '0 && !r_state.quoted))
        else $error("parser at line start with leftover spaces or quote");

    // Once a line type is decided, the parser is back at the line start or waits for the zero byte.
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_res.line_done) |=>
            (r_state.phase == PH_START || r_state.phase == PH_SKIP))
        else $error("line decided but parser did not leave the line");

    // A byte held behind a stalled output register is neither lost nor changed.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_byte)))
        else $error("pending byte dropped while output stalled");

    // The parse state moves only with a byte that produces a result.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("parse state changed without a byte");

endmodule

FILE: sv/ilt_step.sv
module ilt_step
    import ilt_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_result    o_res
);

    // Deferred space count saturates at the smaller of line length minus one
    // and the field maximum.
    localparam int LIMIT_INT = (MAX_LINE - 1 > (1 << SPACE_W) - 1) ?
                               (1 << SPACE_W) - 1 : MAX_LINE - 1;
    localparam logic [SPACE_W-1:0] SP_LIMIT = SPACE_W'(LIMIT_INT);

    logic [SPACE_W-1:0] w_bumped;

    assign w_bumped = (i_state.spaces < SP_LIMIT) ? i_state.spaces + 1'b1 : i_state.spaces;

    always_comb begin
        logic [3:0] ph;
        logic       term;
        t_state     st;
        t_result    res;

        ph   = i_state.phase;
        term = is_term(i_byte);
        st   = i_state;
        res  = '0;

        unique case (i_state.phase)
            PH_START: begin
                if (term) begin
                    res.line_done = 1'b1;
                    res.line_type = T_EMPTY;
                end else if (i_byte == CH_LBRACK) begin
                    ph = PH_SECTION;
                end else if (i_byte != CH_SPACE) begin
                    res.dest       = D_NAME;
                    res.char_valid = 1'b1;
                    res.char_out   = i_byte;
                    ph             = PH_NAME;
                end
            end
            PH_SECTION: begin
                if (i_byte == CH_RBRACK) begin
                    res.line_done = 1'b1;
                    res.line_type = T_SECTION;
                end else if (i_byte == CH_NUL) begin
                    res.line_done = 1'b1;
                    res.line_type = T_SYNTAX;
                end else begin
                    res.dest       = D_SECTION;
                    res.char_valid = 1'b1;
                    res.char_out   = i_byte;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_EQUAL) begin
                    ph = PH_VAL_START;
                end else if (i_byte == CH_SPACE) begin
                    st.spaces = SPACE_W'(1);
                    ph        = PH_NAME_SP;
                end else if (term) begin
                    res.line_done = 1'b1;
                    res.line_type = T_SYNTAX;
                end else begin
                    res.dest       = D_NAME;
                    res.char_valid = 1'b1;
                    res.char_out   = i_byte;
                end
            end
            PH_NAME_SP: begin
                if (i_byte == CH_SPACE) begin
                    st.spaces = w_bumped;
                end else if (i_byte == CH_EQUAL) begin
                    ph = PH_VAL_START;
                end else if (term) begin
                    res.line_done = 1'b1;
                    res.line_type = T_SYNTAX;
                end else begin
                    res.dest        = D_NAME;
                    res.lead_spaces = i_state.spaces;
                    res.char_valid  = 1'b1;
                    res.char_out    = i_byte;
                    st.spaces       = '0;
                    ph              = PH_NAME;
                end
            end
            PH_VAL_START: begin
                if (i_byte == CH_DQUOTE) begin
                    st.quoted = 1'b1;
                    st.spaces = '0;
                    ph        = PH_VAL_SP;
                end else if (term) begin
                    res.line_done = 1'b1;
                    res.line_type = T_EMPTY_VALUE;
                end else if (i_byte != CH_SPACE) begin
                    res.dest       = D_VALUE;
                    res.char_valid = 1'b1;
                    res.char_out   = i_byte;
                    ph             = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (i_byte == CH_DQUOTE) begin
                    st.spaces = '0;
                    ph        = PH_QUOTE_SP;
                end else if (i_byte == CH_SPACE) begin
                    st.spaces = SPACE_W'(1);
                    ph        = PH_VAL_SP;
                end else if (term && !i_state.quoted) begin
                    res.line_done = 1'b1;
                    res.line_type = T_NAME_VALUE;
                end else if (i_byte == CH_NUL) begin
                    res.line_done = 1'b1;
                    res.line_type = T_SYNTAX;
                end else begin
                    res.dest       = D_VALUE;
                    res.char_valid = 1'b1;
                    res.char_out   = i_byte;
                end
            end
            PH_VAL_SP: begin
                if (i_byte == CH_SPACE) begin
                    st.spaces = w_bumped;
                end else if (term && !i_state.quoted) begin
                    res.line_done = 1'b1;
                    res.line_type = T_NAME_VALUE;
                end else if (i_byte == CH_NUL) begin
                    res.line_done = 1'b1;
                    res.line_type = T_SYNTAX;
                end else begin
                    res.lead_spaces = i_state.spaces;
                    st.spaces       = '0;
                    if (i_byte != CH_DQUOTE) begin
                        res.char_valid = 1'b1;
                        res.char_out   = i_byte;
                        ph             = PH_VALUE;
                    end else begin
                        ph = PH_QUOTE_SP;
                    end
                    // A quote with no pending blanks before it appends nothing.
                    if (i_state.spaces != '0 || i_byte != CH_DQUOTE) begin
                        res.dest = D_VALUE;
                    end
                end
            end
            PH_QUOTE_SP: begin
                if (i_byte == CH_SPACE) begin
                    st.spaces = w_bumped;
                end else if (term) begin
                    res.line_done = 1'b1;
                    res.line_type = T_NAME_VALUE;
                end else begin
                    // The quote was not the closing one, so it goes into the value.
                    res.dest        = D_VALUE;
                    res.lead_quote  = 1'b1;
                    res.lead_spaces = i_state.spaces;
                    st.spaces       = '0;
                    if (i_byte != CH_DQUOTE) begin
                        res.char_valid = 1'b1;
                        res.char_out   = i_byte;
                        ph             = PH_VALUE;
                    end
                end
            end
            default: begin
                if (i_byte == CH_NUL) begin
                    ph = PH_START;
                end
            end
        endcase

        if (res.line_done) begin
            ph = (i_byte == CH_NUL) ? PH_START : PH_SKIP;
        end
        if (ph == PH_START) begin
            st.spaces = '0;
            st.quoted = 1'b0;
        end
        st.phase = ph;

        o_state = st;
        o_res   = res;
    end

endmodule

FILE: tb/ini_line_tokenizer_test.sv
`timescale 1ns / 100ps

// Checks the INI line tokenizer one byte at a time. A behavioral copy of the
// parser runs beside the block and predicts the result for every accepted byte.
// The results coming back on the output channel are compared in order against
// those predictions.
module ini_line_tokenizer_test;
    import ilt_pkg::*;

    // The deferred space count stops at the smaller of MAX_LINE - 1 and the
    // largest value that the 12-bit field can hold.
    localparam int SPACE_LIMIT = (MAX_LINE_DEF - 1 > 4095) ? 4095 : MAX_LINE_DEF - 1;

    // Length of the long run of blanks inside a value.
    localparam int BLANK_RUN = 150;

    // The result register sits two stages behind the input, so these extra
    // cycles give the last result time to come out.
    localparam int DRAIN_CYCLES = 4;

    // Shapes of line used by the random stimulus.
    typedef enum int {
        LINE_BLANK,
        LINE_SECTION,
        LINE_PAIR,
        LINE_QUOTED,
        LINE_NOISE,
        LINE_BROKEN
    } t_line_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilt_in_if  in_ch ();
    ilt_out_if out_ch ();

    ini_line_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the parser state.
    logic [3:0]         line_phase;
    logic [SPACE_W-1:0] pending_spaces;
    logic               in_quotes;

    // Results predicted for bytes that were taken but whose result has not come
    // back yet, oldest first.
    t_result expected_tokens[$];

    int error_count  = 0;
    int result_count = 0;
    int live_bytes   = 0;   // Bytes taken while the parser was not skipping.

    // Idle rates, in percent, of the byte sender and of the result receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // ------------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------------

    // Characters that end a line outside an outer-quoted value.
    function automatic logic ends_line(input logic [7:0] c);
        return c == CH_SEMI || c == CH_HASH || c == CH_CR || c == CH_LF || c == CH_NUL;
    endfunction

    // Advances the shadow parser by one byte and returns the result that the
    // block must give for it.
    function automatic t_result tokenize_byte(input logic [7:0] c);
        t_result    r;
        logic [3:0] ph;
        r  = '0;
        ph = line_phase;

        case (ph)
            PH_START: begin
                if (ends_line(c)) begin
                    r.line_done = 1'b1;
                    r.line_type = T_EMPTY;
                end else if (c == CH_LBRACK) begin
                    ph = PH_SECTION;
                end else if (c != CH_SPACE) begin
                    r.dest       = D_NAME;
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                    ph           = PH_NAME;
                end
            end
            PH_SECTION: begin
                if (c == CH_RBRACK) begin
                    r.line_done = 1'b1;
                    r.line_type = T_SECTION;
                end else if (c == CH_NUL) begin
                    r.line_done = 1'b1;
                    r.line_type = T_SYNTAX;
                end else begin
                    r.dest       = D_SECTION;
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                end
            end
            PH_NAME: begin
                if (c == CH_EQUAL) begin
                    ph = PH_VAL_START;
                end else if (c == CH_SPACE) begin
                    pending_spaces = SPACE_W'(1);
                    ph             = PH_NAME_SP;
                end else if (ends_line(c)) begin
                    r.line_done = 1'b1;
                    r.line_type = T_SYNTAX;
                end else begin
                    r.dest       = D_NAME;
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                end
            end
            PH_NAME_SP: begin
                if (c == CH_SPACE) begin
                    if (pending_spaces < SPACE_LIMIT) pending_spaces++;
                end else if (c == CH_EQUAL) begin
                    ph = PH_VAL_START;
                end else if (ends_line(c)) begin
                    r.line_done = 1'b1;
                    r.line_type = T_SYNTAX;
                end else begin
                    r.dest         = D_NAME;
                    r.lead_spaces  = pending_spaces;
                    r.char_valid   = 1'b1;
                    r.char_out     = c;
                    pending_spaces = '0;
                    ph             = PH_NAME;
                end
            end
            PH_VAL_START: begin
                if (c == CH_DQUOTE) begin
                    in_quotes      = 1'b1;
                    pending_spaces = '0;
                    ph             = PH_VAL_SP;
                end else if (ends_line(c)) begin
                    r.line_done = 1'b1;
                    r.line_type = T_EMPTY_VALUE;
                end else if (c != CH_SPACE) begin
                    r.dest       = D_VALUE;
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                    ph           = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (c == CH_DQUOTE) begin
                    pending_spaces = '0;
                    ph             = PH_QUOTE_SP;
                end else if (c == CH_SPACE) begin
                    pending_spaces = SPACE_W'(1);
                    ph             = PH_VAL_SP;
                end else if (ends_line(c) && !in_quotes) begin
                    r.line_done = 1'b1;
                    r.line_type = T_NAME_VALUE;
                end else if (c == CH_NUL) begin
                    r.line_done = 1'b1;
                    r.line_type = T_SYNTAX;
                end else begin
                    r.dest       = D_VALUE;
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                end
            end
            PH_VAL_SP: begin
                if (c == CH_SPACE) begin
                    if (pending_spaces < SPACE_LIMIT) pending_spaces++;
                end else if (ends_line(c) && !in_quotes) begin
                    r.line_done = 1'b1;
                    r.line_type = T_NAME_VALUE;
                end else if (c == CH_NUL) begin
                    r.line_done = 1'b1;
                    r.line_type = T_SYNTAX;
                end else begin
                    r.lead_spaces  = pending_spaces;
                    pending_spaces = '0;
                    if (c != CH_DQUOTE) begin
                        r.char_valid = 1'b1;
                        r.char_out   = c;
                        ph           = PH_VALUE;
                    end else begin
                        ph = PH_QUOTE_SP;
                    end
                    // Only a step that actually appends something names a string.
                    if (r.lead_spaces != '0 || r.char_valid) r.dest = D_VALUE;
                end
            end
            PH_QUOTE_SP: begin
                if (c == CH_SPACE) begin
                    if (pending_spaces < SPACE_LIMIT) pending_spaces++;
                end else if (ends_line(c)) begin
                    r.line_done = 1'b1;
                    r.line_type = T_NAME_VALUE;
                end else begin
                    // The quote held back becomes part of the value once an
                    // ordinary character shows that it was not the closing one.
                    r.dest         = D_VALUE;
                    r.lead_quote   = 1'b1;
                    r.lead_spaces  = pending_spaces;
                    pending_spaces = '0;
                    if (c != CH_DQUOTE) begin
                        r.char_valid = 1'b1;
                        r.char_out   = c;
                        ph           = PH_VALUE;
                    end else begin
                        ph = PH_QUOTE_SP;
                    end
                end
            end
            default: begin
                // Skipping the rest of a line that is already decided.
                if (c == CH_NUL) ph = PH_START;
            end
        endcase

        if (r.line_done) ph = (c == CH_NUL) ? PH_START : PH_SKIP;
        if (ph == PH_START) begin
            pending_spaces = '0;
            in_quotes      = 1'b0;
        end
        line_phase = ph;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver and result checker
    // ------------------------------------------------------------------------

    // Offers one byte, waiting out any idle cycles first, and records the
    // predicted result once the block takes it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (line_phase != PH_SKIP) live_bytes++;
        expected_tokens.push_back(tokenize_byte(b));
    endtask

    // Sends the characters of a string followed by the zero byte that ends
    // the line.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_count, name, got, want));
    endtask

    // The receiver drops ready at random according to its idle rate.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result taken by the receiver is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no byte pending",
                                          result_count));
            end else begin
                want = expected_tokens.pop_front();
                check_field("dest",        out_ch.dest,        want.dest);
                check_field("lead_quote",  out_ch.lead_quote,  want.lead_quote);
                check_field("lead_spaces", out_ch.lead_spaces, want.lead_spaces);
                check_field("char_valid",  out_ch.char_valid,  want.char_valid);
                check_field("char_out",    out_ch.char_out,    want.char_out);
                check_field("line_done",   out_ch.line_done,   want.line_done);
                check_field("line_type",   out_ch.line_type,   want.line_type);
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // A character with no meaning to the parser: anything but the terminators,
    // brackets, equals sign, double quote and space.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (ends_line(c) || c == CH_LBRACK || c == CH_RBRACK ||
                   c == CH_EQUAL || c == CH_DQUOTE || c == CH_SPACE);
        return c;
    endfunction

    task automatic send_blanks(input int max_count);
        repeat ($urandom_range(max_count)) send_byte(CH_SPACE);
    endtask

    // A name or value: ordinary characters, now and then with runs of spaces
    // between them, always ending on an ordinary character.
    task automatic send_word(input int max_len);
        int n;
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++) begin
            if (i != 0 && $urandom_range(4) == 0) send_blanks(3);
            send_byte(word_char());
        end
    endtask

    // A few arbitrary nonzero bytes.
    task automatic send_noise(input int max_count);
        repeat ($urandom_range(max_count)) send_byte(8'($urandom_range(1, 255)));
    endtask

    // Ends a line: maybe blanks, maybe a terminator or comment, then the zero byte.
    task automatic send_line_end();
        send_blanks(2);
        case ($urandom_range(5))
            0: begin
                send_byte(CH_SEMI);
                send_noise(4);
            end
            1: send_byte(CH_HASH);
            2: send_byte(CH_CR);
            3: send_byte(CH_LF);
            default: ;
        endcase
        send_byte(CH_NUL);
    endtask

    // Body of a quoted value, where terminators and brackets are plain text.
    task automatic send_quoted_body(input int max_len);
        logic [7:0] c;
        repeat ($urandom_range(max_len)) begin
            if ($urandom_range(3) == 0) begin
                c = CH_SPACE;
            end else begin
                do c = 8'($urandom_range(1, 255)); while (c == CH_DQUOTE);
            end
            send_byte(c);
        end
    endtask

    function automatic t_line_kind pick_line_kind();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return LINE_BLANK;
        if (r < 23) return LINE_SECTION;
        if (r < 55) return LINE_PAIR;
        if (r < 78) return LINE_QUOTED;
        if (r < 90) return LINE_NOISE;
        return LINE_BROKEN;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Lines with nothing in them: bare zero, blanks, comments and line breaks.
    task automatic test_empty_lines();
        send_byte(CH_NUL);
        send_text("  ");
        send_text(";c");
        send_byte(CH_CR);
        send_byte(CH_NUL);
    endtask

    // Section headers: text after the closing bracket, an unclosed header and
    // bytes at both ends of the range.
    task automatic test_sections();
        send_text("[s x]y");
        send_byte(CH_LBRACK);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(CH_NUL);
    endtask

    // Name and value pairs: blanks inside and around both, trailing blanks,
    // an empty value and a name with no equals sign.
    task automatic test_pairs();
        send_text(" a b = c  d ");
        send_text("k=#");
        send_text("n ;");
    endtask

    // Outer-quoted values: terminators kept inside, a quote inside the value,
    // a blank after the closing quote, and a value left open at the zero byte.
    task automatic test_quoted_values();
        send_text("k=\"; \"\" x\" ");
        send_text("v=\"a");
    endtask

    // A long run of blanks inside a value, so that the pending count grows
    // well past its low bits before it is released.
    task automatic test_long_blank_run();
        send_byte(8'h6B);
        send_byte(CH_EQUAL);
        send_byte(8'h76);
        repeat (BLANK_RUN) send_byte(CH_SPACE);
        send_byte(8'h77);
        send_byte(CH_NUL);
    endtask

    // Mostly well-formed lines with random content, plus noise and broken
    // lines, until the given number of bytes has reached the parser.
    task automatic test_random_lines(input int n);
        int goal;
        goal = live_bytes + n;
        while (live_bytes < goal) begin
            case (pick_line_kind())
                LINE_BLANK: begin
                    send_blanks(3);
                    send_line_end();
                end
                LINE_SECTION: begin
                    send_blanks(2);
                    send_byte(CH_LBRACK);
                    repeat ($urandom_range(6)) begin
                        send_byte($urandom_range(3) == 0 ? CH_SPACE : word_char());
                    end
                    send_byte(CH_RBRACK);
                    send_noise(3);
                    send_byte(CH_NUL);
                end
                LINE_PAIR: begin
                    send_blanks(2);
                    send_word(6);
                    send_blanks(2);
                    send_byte(CH_EQUAL);
                    send_blanks(2);
                    if ($urandom_range(9) != 0) send_word(8);
                    send_line_end();
                end
                LINE_QUOTED: begin
                    send_word(4);
                    send_byte(CH_EQUAL);
                    send_blanks(2);
                    send_byte(CH_DQUOTE);
                    send_quoted_body(8);
                    send_byte(CH_DQUOTE);
                    if ($urandom_range(2) == 0) begin
                        send_blanks(3);
                        if ($urandom_range(1) == 0) send_byte(CH_DQUOTE);
                        send_word(4);
                    end
                    send_line_end();
                end
                LINE_NOISE: begin
                    send_noise(10);
                    send_byte(CH_NUL);
                end
                default: begin
                    // Lines that go wrong part way: an open section, an open
                    // quote, or a name cut off by some stray byte.
                    case ($urandom_range(2))
                        0: begin
                            send_byte(CH_LBRACK);
                            send_word(4);
                        end
                        1: begin
                            send_word(3);
                            send_byte(CH_EQUAL);
                            send_byte(CH_DQUOTE);
                            send_quoted_body(6);
                        end
                        default: begin
                            send_word(4);
                            send_blanks(2);
                            send_noise(3);
                        end
                    endcase
                    send_byte(CH_NUL);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.byte_in <= '0;

        line_phase     = PH_START;
        pending_spaces = '0;
        in_quotes      = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender rarely idle, receiver mostly stalled.
        send_idle_pct = 9;
        recv_idle_pct = 67;
        test_empty_lines();
        test_sections();
        test_pairs();
        test_quoted_values();
        test_random_lines(240);

        // Sender mostly idle, receiver rarely stalled.
        send_idle_pct = 67;
        recv_idle_pct = 9;
        test_random_lines(240);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_blank_run();
        test_random_lines(240);

        // The last byte was taken at the edge just passed; withdraw it at once.
        in_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // A correct run ends well before this point; anything past it means the
    // block has hung.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
